>>> rtl/tri3_conduction_stiffness_assert.svh
// Assertion helpers for the triangle stiffness block.
// Both macros sample on aclk and are idle while aresetn is low.
`ifndef TRI3_CONDUCTION_STIFFNESS_ASSERT_SVH
`define TRI3_CONDUCTION_STIFFNESS_ASSERT_SVH
`ifndef ASSERT_OFF
`define TRI3CS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("tri3cs assertion failed");
`define TRI3CS_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error("tri3cs forbidden condition seen");
`else
`define TRI3CS_ASSERT(lbl, prop)
`define TRI3CS_ASSERT_NEVER(lbl, expr)
`endif
`endif

>>> rtl/tri3cs_pkg.sv
package tri3cs_pkg;

    localparam int COORD_W = 32;
    localparam int COND_W  = 32;
    localparam int N_COORD = 6;
    localparam int N_COND  = 4;
    localparam int IN_W    = N_COORD * COORD_W;
    localparam int K_W     = 64;
    localparam int N_ENT   = 9;
    localparam int OUT_W   = N_ENT * K_W;
    localparam int CFG_AW  = 2;

    localparam int DIFF_W  = COORD_W + 1;
    localparam int GG_W    = 2 * DIFF_W;
    localparam int GG_LO   = DIFF_W;
    localparam int PH_W    = COND_W + GG_W - GG_LO;
    localparam int PL_W    = COND_W + GG_LO + 1;
    localparam int DET_W   = GG_W + 1;
    localparam int NUM_W   = 100;
    localparam int FRAC_UP = 16;
    localparam int TOP_W   = NUM_W + FRAC_UP + 1;
    localparam int Q_W     = 64;
    localparam int DIV_W   = DET_W + 1;
    localparam int STEPS   = Q_W;
    localparam int N_PROD  = N_COND * N_ENT;

    localparam logic [CFG_AW-1:0] REG_COND_XX = 2'd0;
    localparam logic [CFG_AW-1:0] REG_COND_XY = 2'd1;
    localparam logic [CFG_AW-1:0] REG_COND_YX = 2'd2;
    localparam logic [CFG_AW-1:0] REG_COND_YY = 2'd3;

    localparam logic [COND_W-1:0] COND_ONE = 32'h0001_0000;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [Q_W-1:0]   bits;
        logic             neg;
        logic             ovf;
    } lane_t;

    typedef struct packed {
        logic                    vld;
        logic                    bad;
        logic [DIV_W-1:0]        den;
        lane_t [N_ENT-1:0]       lane;
    } div_bus_t;

    function automatic logic signed [DIFF_W-1:0] sext_coord(logic [COORD_W-1:0] v);
        return {v[COORD_W-1], v};
    endfunction

endpackage

>>> rtl/tri3cs_front.sv
module tri3cs_front (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  logic                                             en,
    input  logic                                             in_vld,
    input  logic [tri3cs_pkg::IN_W-1:0]                      in_data,
    input  logic [tri3cs_pkg::N_COND-1:0][tri3cs_pkg::COND_W-1:0] cond,
    output tri3cs_pkg::div_bus_t                             div_out
);
    import tri3cs_pkg::*;

    logic [COORD_W-1:0] crd [N_COORD];

    logic                     v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [DIFF_W-1:0] g_reg [6];
    logic signed [DIFF_W-1:0] g_next [6];
    logic signed [GG_W-1:0]   gg_reg [N_PROD];
    logic signed [GG_W-1:0]   gg_next [N_PROD];
    logic signed [GG_W-1:0]   p1_reg, p2_reg, p1_next, p2_next;
    logic signed [DET_W-1:0]  det3_reg, det3_next, det4_reg;
    logic signed [PH_W-1:0]   ph_reg [N_PROD];
    logic signed [PH_W-1:0]   ph_next [N_PROD];
    logic signed [PL_W-1:0]   pl_reg [N_PROD];
    logic signed [PL_W-1:0]   pl_next [N_PROD];
    logic signed [NUM_W-1:0]  num_reg [N_ENT];
    logic signed [NUM_W-1:0]  num_next [N_ENT];
    logic                     bad4_reg, bad4_next, bad5_reg;
    logic [TOP_W-1:0]         top_reg [N_ENT];
    logic [TOP_W-1:0]         top_next [N_ENT];
    logic [N_ENT-1:0]         neg_reg, neg_next;
    logic [DIV_W-1:0]         den5_reg;
    div_bus_t                 div_reg, div_next;

    for (genvar n = 0; n < N_COORD; n++) begin : g_crd
        assign crd[n] = in_data[n*COORD_W +: COORD_W];
    end

    // Node order in the beat is x0, y0, x1, y1, x2, y2.
    // Row 0 of G holds y differences, row 1 holds x differences.
    always_comb begin
        g_next[0] = sext_coord(crd[3]) - sext_coord(crd[5]);
        g_next[1] = sext_coord(crd[5]) - sext_coord(crd[1]);
        g_next[2] = sext_coord(crd[1]) - sext_coord(crd[3]);
        g_next[3] = sext_coord(crd[4]) - sext_coord(crd[2]);
        g_next[4] = sext_coord(crd[0]) - sext_coord(crd[4]);
        g_next[5] = sext_coord(crd[2]) - sext_coord(crd[0]);
    end

    // Product index is (a*2+b)*9 + i*3 + j for G[a][i]*G[b][j].
    for (genvar ab = 0; ab < N_COND; ab++) begin : g_ab
        for (genvar e = 0; e < N_ENT; e++) begin : g_e
            localparam int K = ab * N_ENT + e;
            assign gg_next[K] = g_reg[(ab/2)*3 + e/3] * g_reg[(ab%2)*3 + e%3];
            assign ph_next[K] = $signed(cond[ab]) * $signed(gg_reg[K][GG_W-1:GG_LO]);
            assign pl_next[K] = $signed(cond[ab]) * $signed({1'b0, gg_reg[K][GG_LO-1:0]});
        end
    end

    // The determinant equals G[1][2]*G[0][1] - G[1][1]*G[0][2].
    assign p1_next   = g_reg[5] * g_reg[1];
    assign p2_next   = g_reg[4] * g_reg[2];
    assign det3_next = $signed({p1_reg[GG_W-1], p1_reg}) - $signed({p2_reg[GG_W-1], p2_reg});
    assign bad4_next = det3_reg[DET_W-1] || (det3_reg == '0);

    always_comb begin
        logic signed [NUM_W-1:0] acc;
        logic signed [NUM_W-1:0] hi_part;
        logic signed [NUM_W-1:0] lo_part;
        for (int e = 0; e < N_ENT; e++) begin
            acc = '0;
            for (int ab = 0; ab < N_COND; ab++) begin
                hi_part = $signed({{(NUM_W-PH_W-GG_LO){ph_reg[ab*N_ENT+e][PH_W-1]}},
                                   ph_reg[ab*N_ENT+e], {GG_LO{1'b0}}});
                lo_part = $signed({{(NUM_W-PL_W){pl_reg[ab*N_ENT+e][PL_W-1]}},
                                   pl_reg[ab*N_ENT+e]});
                acc = acc + hi_part + lo_part;
            end
            num_next[e] = acc;
        end
    end

    // Rounding adds detJ before dividing by 2*detJ, working on the magnitude.
    always_comb begin
        logic [NUM_W-1:0] mag;
        for (int e = 0; e < N_ENT; e++) begin
            neg_next[e] = num_reg[e][NUM_W-1];
            mag = neg_next[e] ? NUM_W'(-num_reg[e]) : NUM_W'(num_reg[e]);
            top_next[e] = {1'b0, mag, {FRAC_UP{1'b0}}} + TOP_W'(det4_reg[DET_W-2:0]);
        end
    end

    // Quotient bits at weight 2^64 and up only mean saturation.
    always_comb begin
        logic [DIV_W-1:0] head;
        div_next.vld = v5_reg;
        div_next.bad = bad5_reg;
        div_next.den = den5_reg;
        for (int e = 0; e < N_ENT; e++) begin
            head = DIV_W'(top_reg[e][TOP_W-1:Q_W]);
            div_next.lane[e].ovf  = (head >= den5_reg);
            div_next.lane[e].rem  = div_next.lane[e].ovf ? '0 : head;
            div_next.lane[e].bits = top_reg[e][Q_W-1:0];
            div_next.lane[e].neg  = neg_reg[e];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            div_reg.vld <= 1'b0;
        end else if (en) begin
            v1_reg      <= in_vld;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            div_reg     <= div_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g_reg    <= g_next;
            gg_reg   <= gg_next;
            p1_reg   <= p1_next;
            p2_reg   <= p2_next;
            det3_reg <= det3_next;
            ph_reg   <= ph_next;
            pl_reg   <= pl_next;
            det4_reg <= det3_reg;
            bad4_reg <= bad4_next;
            num_reg  <= num_next;
            bad5_reg <= bad4_reg;
            den5_reg <= {1'b0, det4_reg[DET_W-2:0], 1'b0};
            top_reg  <= top_next;
            neg_reg  <= neg_next;
        end
    end

    assign div_out = div_reg;

endmodule

>>> rtl/tri3cs_div_step.sv
module tri3cs_div_step (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  tri3cs_pkg::div_bus_t d_in,
    output tri3cs_pkg::div_bus_t d_out
);
    import tri3cs_pkg::*;

    div_bus_t d_reg, d_next;

    // One restoring step per lane: the dividend bits shift out at the top
    // of bits while the quotient bits shift in at the bottom.
    always_comb begin
        logic [DIV_W:0] trial;
        logic           ge;
        d_next = d_in;
        for (int e = 0; e < N_ENT; e++) begin
            trial = {d_in.lane[e].rem, d_in.lane[e].bits[Q_W-1]};
            ge    = (trial >= {1'b0, d_in.den});
            d_next.lane[e].rem  = ge ? DIV_W'(trial - {1'b0, d_in.den}) : trial[DIV_W-1:0];
            d_next.lane[e].bits = {d_in.lane[e].bits[Q_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg.vld <= 1'b0;
        end else if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

>>> rtl/tri3_conduction_stiffness.sv
// Heat-conduction stiffness of one linear triangle, K = 0.5*detJ*B^T*C*B, with C
// taken from the four conductivity registers. One triangle enters per clock unless
// the pipeline is stalled; its nine Q32.32 entries pass through six front stages,
// 64 restoring divider steps (one quotient bit per stage for all nine entries)
// and the output register. The whole pipeline stalls while a result beat waits
// on m_tready. bad_area flags a zero or negative determinant and then all
// entries are zero. Write the conductivity registers only while no triangle is
// in flight.
`include "tri3_conduction_stiffness_assert.svh"

module tri3_conduction_stiffness (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [tri3cs_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [tri3cs_pkg::COND_W-1:0]     cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // node0_x, node0_y, node1_x, node1_y, node2_x, node2_y
    input  logic [tri3cs_pkg::IN_W-1:0]       s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // k00, k01, k02, k10, k11, k12, k20, k21, k22
    output logic [tri3cs_pkg::OUT_W-1:0]      m_tdata,
    // bad_area
    output logic [0:0]                        m_tuser
);
    import tri3cs_pkg::*;

    logic [N_COND-1:0][COND_W-1:0] cond_reg;
    logic                          en;
    div_bus_t                      stage_bus [STEPS+1];
    logic                          m_tvalid_reg;
    logic [OUT_W-1:0]              m_tdata_reg, m_tdata_next;
    logic                          m_tuser_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cond_reg[REG_COND_XX] <= COND_ONE;
            cond_reg[REG_COND_XY] <= '0;
            cond_reg[REG_COND_YX] <= '0;
            cond_reg[REG_COND_YY] <= COND_ONE;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_COND_XX: cond_reg[REG_COND_XX] <= cfg_wdata;
                REG_COND_XY: cond_reg[REG_COND_XY] <= cfg_wdata;
                REG_COND_YX: cond_reg[REG_COND_YX] <= cfg_wdata;
                REG_COND_YY: cond_reg[REG_COND_YY] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    tri3cs_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (s_tvalid),
        .in_data (s_tdata),
        .cond    (cond_reg),
        .div_out (stage_bus[0])
    );

    for (genvar s = 0; s < STEPS; s++) begin : g_div
        tri3cs_div_step u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .d_in    (stage_bus[s]),
            .d_out   (stage_bus[s+1])
        );
    end

    // A quotient of 2^63 or more saturates; for a negative entry exactly 2^63
    // lands on the most negative code, which is the same pattern.
    always_comb begin
        lane_t        ln;
        logic [K_W-1:0] val;
        for (int e = 0; e < N_ENT; e++) begin
            ln = stage_bus[STEPS].lane[e];
            if (ln.ovf || ln.bits[Q_W-1]) begin
                val = ln.neg ? {1'b1, {(K_W-1){1'b0}}} : {1'b0, {(K_W-1){1'b1}}};
            end else begin
                val = ln.neg ? K_W'(-ln.bits) : K_W'(ln.bits);
            end
            m_tdata_next[e*K_W +: K_W] = stage_bus[STEPS].bad ? '0 : val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= stage_bus[STEPS].vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= stage_bus[STEPS].bad;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `TRI3CS_ASSERT(a_bad_zero, m_tvalid && m_tuser[0] |-> m_tdata == '0)
    `TRI3CS_ASSERT(a_den_ok, stage_bus[0].vld && !stage_bus[0].bad |->
        stage_bus[0].den != '0 && !stage_bus[0].den[DIV_W-1])
    `TRI3CS_ASSERT_NEVER(a_rem_range, stage_bus[STEPS].vld && !stage_bus[STEPS].bad &&
        !stage_bus[STEPS].lane[0].ovf &&
        (stage_bus[STEPS].lane[0].rem >= stage_bus[STEPS].den))

endmodule
